>>> rtl/tlvrd_pkg.sv
// Shared types and codes for the TLV response decoder.
package tlvrd_pkg;

   // record type identifiers as they appear on the wire
   localparam logic [7:0] HOST_ID = 8'd1;
   localparam logic [7:0] PORT_ID = 8'd2;
   localparam logic [7:0] PATH_ID = 8'd3;
   localparam logic [7:0] FLAG_ID = 8'd4;

   // record_type holds the identifier minus one
   localparam logic [1:0] RT_HOST      = 2'd0;
   localparam logic [1:0] RT_PORT      = 2'd1;
   localparam logic [1:0] RT_PATH      = 2'd2;
   localparam logic [1:0] RT_AVAILABLE = 2'd3;

   localparam logic [7:0] PORT_LEN      = 8'd4;
   localparam logic [7:0] AVAILABLE_LEN = 8'd1;
   localparam logic [7:0] FLAG_TRUE     = 8'd1;

   // decoder phases
   localparam logic [1:0] PH_TYPE  = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_SKIP  = 2'd3;

   // event codes
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_STRING = 2'd1;
   localparam logic [1:0] EV_PORT   = 2'd2;
   localparam logic [1:0] EV_FLAG   = 2'd3;

   // status codes
   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_BADLEN  = 3'd3;
   localparam logic [2:0] ST_TRUNC   = 3'd4;

   typedef struct packed {
      logic [1:0]  phase;
      logic [1:0]  record_type;
      logic [7:0]  bytes_left;
      logic [31:0] port_accumulator;
   } state_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic        which_string;
      logic [7:0]  string_byte;
      logic        string_valid;
      logic        string_end;
      logic [31:0] port_value;
      logic        update_available;
      logic [2:0]  status;
   } result_type;

endpackage

>>> rtl/tlvrd_if.sv
// Request and response channel interfaces for the TLV response decoder.
interface tlvrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, data_byte, final_byte, input ready);
   modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface tlvrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic        which_string;
   logic [7:0]  string_byte;
   logic        string_valid;
   logic        string_end;
   logic [31:0] port_value;
   logic        update_available;
   logic [2:0]  status;

   modport source (output valid, event_res, which_string, string_byte, string_valid,
                   string_end, port_value, update_available, status, input ready);
   modport sink (input valid, event_res, which_string, string_byte, string_valid,
                 string_end, port_value, update_available, status, output ready);
endinterface

>>> rtl/tlvrd_step.sv
// Per-byte decode: next decoder state and the result for one input byte.
module tlvrd_step (
   input  tlvrd_pkg::state_type  cur,
   input  logic [7:0]            data_byte,
   input  logic                  final_byte,
   output tlvrd_pkg::state_type  nxt,
   output tlvrd_pkg::result_type res
);

   logic        rec_done;
   logic [7:0]  bl_dec;
   logic [31:0] acc_sh;

   assign bl_dec = cur.bytes_left - 8'd1;
   assign acc_sh = {cur.port_accumulator[23:0], data_byte};

   always_comb begin
      nxt      = cur;
      res      = '0;
      rec_done = 1'b0;
      case (cur.phase)
         tlvrd_pkg::PH_LEN: begin
            if ((cur.record_type == tlvrd_pkg::RT_PORT && data_byte != tlvrd_pkg::PORT_LEN) ||
                (cur.record_type == tlvrd_pkg::RT_AVAILABLE &&
                 data_byte != tlvrd_pkg::AVAILABLE_LEN)) begin
               res.status = tlvrd_pkg::ST_BADLEN;
               nxt.phase  = tlvrd_pkg::PH_SKIP;
            end else if (data_byte == 8'd0) begin
               // empty string: end mark only
               res.event_res    = tlvrd_pkg::EV_STRING;
               res.which_string = (cur.record_type == tlvrd_pkg::RT_PATH);
               res.string_end   = 1'b1;
               rec_done         = 1'b1;
            end else begin
               nxt.bytes_left       = data_byte;
               nxt.port_accumulator = '0;
               nxt.phase            = tlvrd_pkg::PH_VALUE;
            end
         end
         tlvrd_pkg::PH_VALUE: begin
            nxt.bytes_left = bl_dec;
            if (cur.record_type == tlvrd_pkg::RT_PORT) begin
               nxt.port_accumulator = acc_sh;
               if (bl_dec == 8'd0) begin
                  res.event_res  = tlvrd_pkg::EV_PORT;
                  res.port_value = acc_sh;
                  rec_done       = 1'b1;
               end
            end else if (cur.record_type == tlvrd_pkg::RT_AVAILABLE) begin
               res.event_res        = tlvrd_pkg::EV_FLAG;
               res.update_available = (data_byte == tlvrd_pkg::FLAG_TRUE);
               nxt.bytes_left       = 8'd0;
               rec_done             = 1'b1;
            end else begin
               res.event_res    = tlvrd_pkg::EV_STRING;
               res.which_string = (cur.record_type == tlvrd_pkg::RT_PATH);
               res.string_byte  = data_byte;
               res.string_valid = 1'b1;
               if (bl_dec == 8'd0) begin
                  res.string_end = 1'b1;
                  rec_done       = 1'b1;
               end
            end
         end
         tlvrd_pkg::PH_SKIP: begin
            nxt.phase = tlvrd_pkg::PH_SKIP;
         end
         default: begin
            if (data_byte inside {[tlvrd_pkg::HOST_ID:tlvrd_pkg::FLAG_ID]}) begin
               nxt.record_type = data_byte[1:0] - 2'd1;
               nxt.phase       = tlvrd_pkg::PH_LEN;
            end else begin
               res.status = tlvrd_pkg::ST_UNKNOWN;
               nxt.phase  = tlvrd_pkg::PH_SKIP;
            end
         end
      endcase

      if (rec_done) begin
         nxt.phase = tlvrd_pkg::PH_TYPE;
      end

      if (final_byte) begin
         if (res.status == tlvrd_pkg::ST_BUSY && nxt.phase != tlvrd_pkg::PH_SKIP) begin
            res.status = (nxt.phase == tlvrd_pkg::PH_TYPE) ? tlvrd_pkg::ST_OK
                                                           : tlvrd_pkg::ST_TRUNC;
         end
         nxt.phase = tlvrd_pkg::PH_TYPE;
      end
   end

endmodule

>>> rtl/tlvrd_out_reg.sv
// Result register driving the response channel.
module tlvrd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tlvrd_pkg::result_type res_in,
   output logic                  can_load,
   tlvrd_rsp_if.source           rsp_ch
);

   logic                  valid_ff;
   logic                  valid_in;
   tlvrd_pkg::result_type data_ff;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res_in;
      end
   end

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.event_res        = data_ff.event_res;
   assign rsp_ch.which_string     = data_ff.which_string;
   assign rsp_ch.string_byte      = data_ff.string_byte;
   assign rsp_ch.string_valid     = data_ff.string_valid;
   assign rsp_ch.string_end       = data_ff.string_end;
   assign rsp_ch.port_value       = data_ff.port_value;
   assign rsp_ch.update_available = data_ff.update_available;
   assign rsp_ch.status           = data_ff.status;

endmodule

>>> rtl/tlv_response_decoder.sv
// TLV response decoder top level: decoder state, per-byte decode and result register.
// Response: registered, on rsp_ch in the cycle after its request byte is accepted.
// Throughput: one byte per cycle unless rsp_ch stalls; state advances a single step per byte.
// Backpressure: req_ch.ready drops only while the result register holds an untaken response.
// Reset (synchronous, active high): decoder expects a type byte, counters and
// port accumulator cleared, response channel empty.
module tlv_response_decoder (
   input logic         clock,
   input logic         reset,
   tlvrd_req_if.sink   req_ch,
   tlvrd_rsp_if.source rsp_ch
);

   tlvrd_pkg::state_type  state_ff;
   tlvrd_pkg::state_type  state_in;
   tlvrd_pkg::result_type step_res;
   logic                  can_load;
   logic                  req_take;

   // a transaction is taken whenever the result register is empty or draining
   assign req_ch.ready = can_load;
   assign req_take     = req_ch.valid && can_load;

   tlvrd_step u_step (
      .cur        (state_ff),
      .data_byte  (req_ch.data_byte),
      .final_byte (req_ch.final_byte),
      .nxt        (state_in),
      .res        (step_res)
   );

   // decoder state only moves on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase            <= tlvrd_pkg::PH_TYPE;
         state_ff.record_type      <= 2'd0;
         state_ff.bytes_left       <= 8'd0;
         state_ff.port_accumulator <= 32'd0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   tlvrd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .res_in   (step_res),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

   // final byte always returns the decoder to the type phase
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      req_take && req_ch.final_byte |=> state_ff.phase == tlvrd_pkg::PH_TYPE)
      else $error("decoder not idle after final byte");

   // value phase always has bytes outstanding
   a_value_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == tlvrd_pkg::PH_VALUE |-> state_ff.bytes_left != 8'd0)
      else $error("value phase with zero bytes left");

   // a string character only comes with a string event
   a_string_event: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.string_valid |-> rsp_ch.event_res == tlvrd_pkg::EV_STRING)
      else $error("string byte without string event");

   // error responses carry no event
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == tlvrd_pkg::ST_UNKNOWN ||
                       rsp_ch.status == tlvrd_pkg::ST_BADLEN)
      |-> rsp_ch.event_res == tlvrd_pkg::EV_NONE)
      else $error("event reported with decode error");

   // an error on a non-final byte leaves the decoder skipping
   a_skip_after_error: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_ch.final_byte && (step_res.status == tlvrd_pkg::ST_UNKNOWN ||
                                         step_res.status == tlvrd_pkg::ST_BADLEN)
      |=> state_ff.phase == tlvrd_pkg::PH_SKIP)
      else $error("decoder not skipping after error");

endmodule
